/* rtl/core/strict_local_maximum_peak_search_macros.svh */
// Assertion macros for the peak search block
`ifndef STRICT_LOCAL_MAXIMUM_PEAK_SEARCH_MACROS_SVH
`define STRICT_LOCAL_MAXIMUM_PEAK_SEARCH_MACROS_SVH
`ifndef ASSERT_OFF
`define SLMPS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define SLMPS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define SLMPS_ASSERT(lbl, prop, msg)
`define SLMPS_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/slmps_pkg.sv */
// Shared types and constants of the peak search block
`timescale 1ns / 1ps
`default_nettype none

package slmps_pkg;

   localparam int CFG_BITS      = 7;
   localparam int CSR_ADDR_BITS = 2;
   localparam int POS_BITS      = 6;
   localparam int PEAK_BITS     = 32;
   localparam int RSP_DEPTH     = 8;
   localparam int RSP_PTR_BITS  = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS  = $clog2(RSP_DEPTH + 1);

   localparam logic [CSR_ADDR_BITS-1:0] CSR_ROWS_IN_USE = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COLS_IN_USE = 2'd1;

   typedef struct packed {
      logic                        found;
      logic signed [PEAK_BITS-1:0] peak_value;
      logic [POS_BITS-1:0]         peak_row;
      logic [POS_BITS-1:0]         peak_col;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/core/strict_local_maximum_peak_search.sv */
// Streaming strict 8-neighbor local maximum peak search over a raster frame
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_pixel_value
//  rsp     | out       | rsp_valid / rsp_ready | rsp_found, rsp_peak_value, rsp_peak_row/col
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
// One item per cycle while req_ready is high. Two line stores feed a 3x3 window; four judge units (interior and
// right edge, for the row above and for the last row) sit between the window register and
// a pair-reduce register, then the running best and a merge stage.
// The result of a frame passes the window, judge, pair-reduce and snapshot registers and the result queue before rsp.
// Results queue in an 8-entry buffer; a frame-final item waits only while 8 are pending.
// reset clears counters, sizes (1x1) and the running best; line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "strict_local_maximum_peak_search_macros.svh"

module strict_local_maximum_peak_search
   import slmps_pkg::*;
#(
   parameter int MAX_DIM    = 64,
   parameter int VALUE_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [VALUE_BITS-1:0] req_pixel_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic signed [PEAK_BITS-1:0]  rsp_peak_value,
   output logic [POS_BITS-1:0]          rsp_peak_row,
   output logic [POS_BITS-1:0]          rsp_peak_col,
   input  logic                         csr_we,
   input  logic [CSR_ADDR_BITS-1:0]     csr_index,
   input  logic [CFG_BITS-1:0]          csr_wdata
);

   localparam int CNT_BITS = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

   typedef logic signed [VALUE_BITS-1:0] val_type;
   typedef logic [CNT_BITS-1:0]          cnt_type;

   function automatic cnt_type dim_m1(input logic [CFG_BITS-1:0] v);
      logic [31:0] ext;
      ext = {{(32-CFG_BITS){1'b0}}, v};
      if (ext == 32'd0) begin
         dim_m1 = '0;
      end else if (ext > 32'(MAX_DIM)) begin
         dim_m1 = CNT_BITS'(MAX_DIM - 1);
      end else begin
         dim_m1 = CNT_BITS'(ext - 32'd1);
      end
   endfunction

   // configuration and frame position
   cnt_type rows_m1_ff, cols_m1_ff;
   cnt_type row_ff, row_in, col_ff, col_in;
   logic    csr_hit, accept, at_last_row, at_last_col, at_final;

   assign csr_hit     = csr_we && (csr_index == CSR_ROWS_IN_USE || csr_index == CSR_COLS_IN_USE);
   assign at_last_row = (row_ff == rows_m1_ff);
   assign at_last_col = (col_ff == cols_m1_ff);
   assign at_final    = at_last_row && at_last_col;
   assign accept      = req_valid && req_ready;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (csr_hit) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (at_last_col) begin
            col_in = '0;
            row_in = at_last_row ? '0 : row_ff + CNT_BITS'(1);
         end else begin
            col_in = col_ff + CNT_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_m1_ff <= '0;
         cols_m1_ff <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
      end else begin
         if (csr_we && csr_index == CSR_ROWS_IN_USE) begin
            rows_m1_ff <= dim_m1(csr_wdata);
         end
         if (csr_we && csr_index == CSR_COLS_IN_USE) begin
            cols_m1_ff <= dim_m1(csr_wdata);
         end
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // line stores, read one column ahead
   val_type upper_mem [MAX_DIM];
   val_type middle_mem [MAX_DIM];
   val_type top_rd_ff, mid_rd_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         upper_mem[col_ff]  <= mid_rd_ff;
         middle_mem[col_ff] <= req_pixel_value;
      end
      if (accept && col_in == col_ff) begin
         top_rd_ff <= mid_rd_ff;
         mid_rd_ff <= req_pixel_value;
      end else begin
         top_rd_ff <= upper_mem[col_in];
         mid_rd_ff <= middle_mem[col_in];
      end
   end

   // stage 1: 3x3 window
   val_type w_ff [9];
   logic    s1_valid_ff, s1_last_row_ff, s1_last_col_ff;
   cnt_type s1_row_ff, s1_col_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         w_ff[0] <= w_ff[1];
         w_ff[1] <= w_ff[2];
         w_ff[2] <= top_rd_ff;
         w_ff[3] <= w_ff[4];
         w_ff[4] <= w_ff[5];
         w_ff[5] <= mid_rd_ff;
         w_ff[6] <= w_ff[7];
         w_ff[7] <= w_ff[8];
         w_ff[8] <= req_pixel_value;
         s1_row_ff      <= row_ff;
         s1_col_ff      <= col_ff;
         s1_last_row_ff <= at_last_row;
         s1_last_col_ff <= at_last_col;
      end
   end

   // stage 2: judges
   logic r_ge1, r_ge2, c_ge1, c_ge2;
   logic hit_a, hit_b, hit_c, hit_d;

   assign r_ge1 = (s1_row_ff != '0);
   assign r_ge2 = (s1_row_ff > CNT_BITS'(1));
   assign c_ge1 = (s1_col_ff != '0);
   assign c_ge2 = (s1_col_ff > CNT_BITS'(1));

   // interior cell of the row above, centered on w4
   assign hit_a = s1_valid_ff && r_ge1 && c_ge1
      && (!(r_ge2 && c_ge2) || w_ff[0] < w_ff[4]) && (!r_ge2 || w_ff[1] < w_ff[4])
      && (!r_ge2 || w_ff[2] < w_ff[4]) && (!c_ge2 || w_ff[3] < w_ff[4])
      && (w_ff[5] < w_ff[4]) && (!c_ge2 || w_ff[6] < w_ff[4])
      && (w_ff[7] < w_ff[4]) && (w_ff[8] < w_ff[4]);
   // right edge cell of the row above, centered on w5
   assign hit_b = s1_valid_ff && r_ge1 && s1_last_col_ff
      && (!(r_ge2 && c_ge1) || w_ff[1] < w_ff[5]) && (!r_ge2 || w_ff[2] < w_ff[5])
      && (!c_ge1 || w_ff[4] < w_ff[5]) && (!c_ge1 || w_ff[7] < w_ff[5])
      && (w_ff[8] < w_ff[5]);
   // last row, no row below, centered on w7
   assign hit_c = s1_valid_ff && s1_last_row_ff && c_ge1
      && (!(r_ge1 && c_ge2) || w_ff[3] < w_ff[7]) && (!r_ge1 || w_ff[4] < w_ff[7])
      && (!r_ge1 || w_ff[5] < w_ff[7]) && (!c_ge2 || w_ff[6] < w_ff[7])
      && (w_ff[8] < w_ff[7]);
   // last row, last column, centered on w8
   assign hit_d = s1_valid_ff && s1_last_row_ff && s1_last_col_ff
      && (!(r_ge1 && c_ge1) || w_ff[4] < w_ff[8]) && (!r_ge1 || w_ff[5] < w_ff[8])
      && (!c_ge1 || w_ff[7] < w_ff[8]);

   logic    s2_valid_ff, s2_final_ff;
   logic    s2_hit_a_ff, s2_hit_b_ff, s2_hit_c_ff, s2_hit_d_ff;
   val_type s2_va_ff, s2_vb_ff, s2_vc_ff, s2_vd_ff;
   cnt_type s2_row_ff, s2_col_ff;

   always_ff @(posedge clock) begin
      s2_final_ff <= s1_last_row_ff && s1_last_col_ff;
      s2_hit_a_ff <= hit_a;
      s2_hit_b_ff <= hit_b;
      s2_hit_c_ff <= hit_c;
      s2_hit_d_ff <= hit_d;
      s2_va_ff    <= w_ff[4];
      s2_vb_ff    <= w_ff[5];
      s2_vc_ff    <= w_ff[7];
      s2_vd_ff    <= w_ff[8];
      s2_row_ff   <= s1_row_ff;
      s2_col_ff   <= s1_col_ff;
   end

   // stage 3: earlier cell wins a tie within each pair
   logic sel_b, sel_d;
   assign sel_b = s2_hit_b_ff && (!s2_hit_a_ff || s2_vb_ff > s2_va_ff);
   assign sel_d = s2_hit_d_ff && (!s2_hit_c_ff || s2_vd_ff > s2_vc_ff);

   logic    s3_valid_ff, s3_final_ff, s3_m_hit_ff, s3_l_hit_ff;
   val_type s3_m_val_ff, s3_l_val_ff;
   cnt_type s3_m_row_ff, s3_m_col_ff, s3_l_row_ff, s3_l_col_ff;

   always_ff @(posedge clock) begin
      s3_final_ff <= s2_final_ff;
      s3_m_hit_ff <= s2_hit_a_ff || s2_hit_b_ff;
      s3_m_val_ff <= sel_b ? s2_vb_ff : s2_va_ff;
      s3_m_row_ff <= s2_row_ff - CNT_BITS'(1);
      s3_m_col_ff <= sel_b ? s2_col_ff : s2_col_ff - CNT_BITS'(1);
      s3_l_hit_ff <= s2_hit_c_ff || s2_hit_d_ff;
      s3_l_val_ff <= sel_d ? s2_vd_ff : s2_vc_ff;
      s3_l_row_ff <= s2_row_ff;
      s3_l_col_ff <= sel_d ? s2_col_ff : s2_col_ff - CNT_BITS'(1);
   end

   always_ff @(posedge clock) begin
      if (reset || csr_hit) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 4: running best of the upper rows and of the last row; -1 means none
   val_type best_m_val_ff, best_m_val_in, best_l_val_ff, best_l_val_in;
   cnt_type best_m_row_ff, best_m_row_in, best_m_col_ff, best_m_col_in;
   cnt_type best_l_row_ff, best_l_row_in, best_l_col_ff, best_l_col_in;
   logic    take_m, take_l;

   assign take_m = s3_valid_ff && s3_m_hit_ff && (s3_m_val_ff > best_m_val_ff);
   assign take_l = s3_valid_ff && s3_l_hit_ff && (s3_l_val_ff > best_l_val_ff);

   always_comb begin
      best_m_val_in = take_m ? s3_m_val_ff : best_m_val_ff;
      best_m_row_in = take_m ? s3_m_row_ff : best_m_row_ff;
      best_m_col_in = take_m ? s3_m_col_ff : best_m_col_ff;
      best_l_val_in = take_l ? s3_l_val_ff : best_l_val_ff;
      best_l_row_in = take_l ? s3_l_row_ff : best_l_row_ff;
      best_l_col_in = take_l ? s3_l_col_ff : best_l_col_ff;
   end

   logic    snap_valid_ff;
   val_type snap_m_val_ff, snap_l_val_ff;
   cnt_type snap_m_row_ff, snap_m_col_ff, snap_l_row_ff, snap_l_col_ff;

   always_ff @(posedge clock) begin
      if (reset || csr_hit || (s3_valid_ff && s3_final_ff)) begin
         best_m_val_ff <= '1;
         best_m_row_ff <= '0;
         best_m_col_ff <= '0;
         best_l_val_ff <= '1;
         best_l_row_ff <= '0;
         best_l_col_ff <= '0;
      end else begin
         best_m_val_ff <= best_m_val_in;
         best_m_row_ff <= best_m_row_in;
         best_m_col_ff <= best_m_col_in;
         best_l_val_ff <= best_l_val_in;
         best_l_row_ff <= best_l_row_in;
         best_l_col_ff <= best_l_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= s3_valid_ff && s3_final_ff && !csr_hit;
      end
      snap_m_val_ff <= best_m_val_in;
      snap_m_row_ff <= best_m_row_in;
      snap_m_col_ff <= best_m_col_in;
      snap_l_val_ff <= best_l_val_in;
      snap_l_row_ff <= best_l_row_in;
      snap_l_col_ff <= best_l_col_in;
   end

   // stage 5: upper rows come first in raster order, so the last row wins only if larger
   logic    take_last, merged_found;
   val_type merged_val;
   cnt_type merged_row, merged_col;
   rsp_type push_item;

   assign take_last    = snap_l_val_ff > snap_m_val_ff;
   assign merged_val   = take_last ? snap_l_val_ff : snap_m_val_ff;
   assign merged_row   = take_last ? snap_l_row_ff : snap_m_row_ff;
   assign merged_col   = take_last ? snap_l_col_ff : snap_m_col_ff;
   assign merged_found = !merged_val[VALUE_BITS-1];

   always_comb begin
      push_item.found      = merged_found;
      push_item.peak_value = merged_found ? PEAK_BITS'(merged_val) : '0;
      push_item.peak_row   = merged_found ? POS_BITS'(merged_row) : '0;
      push_item.peak_col   = merged_found ? POS_BITS'(merged_col) : '0;
   end

   // result queue and pending count of frame-final items
   rsp_type                 fifo_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_BITS-1:0] fifo_cnt_ff, pending_ff;
   logic                    pop, take_final;

   assign rsp_valid  = (fifo_cnt_ff != '0);
   assign pop        = rsp_valid && rsp_ready;
   assign take_final = accept && at_final;
   assign req_ready  = !at_final || (pending_ff != RSP_CNT_BITS'(RSP_DEPTH));

   always_ff @(posedge clock) begin
      if (snap_valid_ff) begin
         fifo_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         pending_ff  <= '0;
      end else begin
         if (snap_valid_ff) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_PTR_BITS'(1);
         end
         fifo_cnt_ff <= fifo_cnt_ff + RSP_CNT_BITS'(snap_valid_ff) - RSP_CNT_BITS'(pop);
         pending_ff  <= pending_ff + RSP_CNT_BITS'(take_final) - RSP_CNT_BITS'(pop);
      end
   end

   assign rsp_found      = fifo_ff[rd_ptr_ff].found;
   assign rsp_peak_value = fifo_ff[rd_ptr_ff].peak_value;
   assign rsp_peak_row   = fifo_ff[rd_ptr_ff].peak_row;
   assign rsp_peak_col   = fifo_ff[rd_ptr_ff].peak_col;

   `SLMPS_ASSERT(a_queue_within_pending, fifo_cnt_ff <= pending_ff, "queue exceeds pending items")
   `SLMPS_ASSERT_IMP(a_push_has_room, snap_valid_ff, fifo_cnt_ff != RSP_CNT_BITS'(RSP_DEPTH), "result queue overflow")
   `SLMPS_ASSERT_IMP(a_empty_result_zero, rsp_valid && !rsp_found, rsp_peak_value == '0 && rsp_peak_row == '0 && rsp_peak_col == '0, "empty result carries data")

endmodule

`default_nettype wire

/* sim/peak_search_checker.sv */
// Checker that predicts and compares peak search results from the observed channels
`timescale 1ns / 1ps

module peak_search_checker
   import slmps_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic signed [PEAK_BITS-1:0] req_pixel_value,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic                        rsp_found,
   input  logic signed [PEAK_BITS-1:0] rsp_peak_value,
   input  logic [POS_BITS-1:0]         rsp_peak_row,
   input  logic [POS_BITS-1:0]         rsp_peak_col,
   input  logic                        csr_we,
   input  logic [CSR_ADDR_BITS-1:0]    csr_index,
   input  logic [CFG_BITS-1:0]         csr_wdata,
   output int                          mismatches,
   output int                          awaiting
);

   localparam int DIM_LIMIT = 64;

   typedef logic [8:0][PEAK_BITS-1:0] window_type;

   logic [PEAK_BITS-1:0]        upper_row [DIM_LIMIT];
   logic [PEAK_BITS-1:0]        middle_row [DIM_LIMIT];
   window_type                  win;
   int                          row_at;
   int                          col_at;
   int                          n_rows;
   int                          n_cols;
   logic signed [PEAK_BITS-1:0] best_val;
   int                          best_r;
   int                          best_c;
   bit                          best_hit;
   rsp_type                     expected_peaks [$];
   rsp_type                     want;

   function automatic int dim_of(logic [CFG_BITS-1:0] raw);
      if (raw == 0) return 1;
      if (raw > DIM_LIMIT) return DIM_LIMIT;
      return int'(raw);
   endfunction

   function automatic void restart_frame();
      row_at   = 0;
      col_at   = 0;
      best_val = -1;
      best_r   = 0;
      best_c   = 0;
      best_hit = 1'b0;
   endfunction

   // center is nb[4]; a disabled side has no neighbor in the frame
   function automatic void score_candidate(window_type nb, bit up, bit dn, bit lf, bit rt,
                                           int r, int c);
      bit beaten;
      beaten = 1'b0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if ((i != 1 || j != 1) && (i != 0 || up) && (i != 2 || dn) &&
                (j != 0 || lf) && (j != 2 || rt) && $signed(nb[i*3+j]) >= $signed(nb[4]))
               beaten = 1'b1;
         end
      end
      if (!beaten && $signed(nb[4]) > best_val) begin
         best_val = nb[4];
         best_r   = r;
         best_c   = c;
         best_hit = 1'b1;
      end
   endfunction

   function automatic void advance_raster(logic [PEAK_BITS-1:0] pix);
      window_type           rim;
      logic [PEAK_BITS-1:0] top;
      logic [PEAK_BITS-1:0] mid;
      int                   r;
      int                   c;
      int                   cx;
      rsp_type              peak;
      r = row_at;
      c = col_at;
      top = upper_row[c];
      mid = middle_row[c];
      upper_row[c]  = mid;
      middle_row[c] = pix;
      for (int i = 0; i < 3; i++) begin
         win[i*3]   = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = pix;
      if (r >= 1) begin
         if (c >= 1) score_candidate(win, r >= 2, 1'b1, c >= 2, 1'b1, r - 1, c - 1);
         if (c + 1 >= n_cols) begin
            for (int i = 0; i < 3; i++) begin
               rim[i*3]   = win[i*3+1];
               rim[i*3+1] = win[i*3+2];
               rim[i*3+2] = '0;
            end
            score_candidate(rim, r >= 2, 1'b1, c >= 1, 1'b0, r - 1, c);
         end
      end
      if (c + 1 < n_cols) begin
         col_at = c + 1;
         return;
      end
      col_at = 0;
      if (r + 1 < n_rows) begin
         row_at = r + 1;
         return;
      end
      // last row of the frame has no row below it
      for (int x = 0; x < n_cols; x++) begin
         for (int j = 0; j < 3; j++) begin
            cx = x + j;
            if (cx >= 1 && cx - 1 < n_cols) begin
               rim[j]   = upper_row[cx-1];
               rim[3+j] = middle_row[cx-1];
            end else begin
               rim[j]   = '0;
               rim[3+j] = '0;
            end
            rim[6+j] = '0;
         end
         score_candidate(rim, r >= 1, 1'b0, x >= 1, x + 1 < n_cols, r, x);
      end
      peak = '0;
      if (best_hit) begin
         peak.found      = 1'b1;
         peak.peak_value = best_val;
         peak.peak_row   = POS_BITS'(best_r);
         peak.peak_col   = POS_BITS'(best_c);
      end
      expected_peaks.push_back(peak);
      restart_frame();
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIM_LIMIT; k++) begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
         end
         win    = '0;
         n_rows = 1;
         n_cols = 1;
         restart_frame();
         expected_peaks.delete();
         mismatches = 0;
      end else begin
         if (csr_we && csr_index == CSR_ROWS_IN_USE) begin
            n_rows = dim_of(csr_wdata);
            restart_frame();
         end
         if (csr_we && csr_index == CSR_COLS_IN_USE) begin
            n_cols = dim_of(csr_wdata);
            restart_frame();
         end
         if (req_valid && req_ready) advance_raster(req_pixel_value);
         if (rsp_valid && rsp_ready) begin
            if (expected_peaks.size() == 0) begin
               $error("unexpected result: found %0d value %0d row %0d col %0d",
                      rsp_found, rsp_peak_value, rsp_peak_row, rsp_peak_col);
               mismatches++;
            end else begin
               want = expected_peaks.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  mismatches++;
               end
               if (rsp_peak_value !== want.peak_value) begin
                  $error("peak_value: expected %0d, got %0d", want.peak_value, rsp_peak_value);
                  mismatches++;
               end
               if (rsp_peak_row !== want.peak_row) begin
                  $error("peak_row: expected %0d, got %0d", want.peak_row, rsp_peak_row);
                  mismatches++;
               end
               if (rsp_peak_col !== want.peak_col) begin
                  $error("peak_col: expected %0d, got %0d", want.peak_col, rsp_peak_col);
                  mismatches++;
               end
            end
         end
      end
      awaiting = expected_peaks.size();
   end

endmodule

/* sim/tb_strict_local_maximum_peak_search.sv */
// Testbench top for the peak search block: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module tb_strict_local_maximum_peak_search;
   import slmps_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE_3 = 2'd3;
   localparam int ITEM_TARGET    = 1900;
   localparam int DRAIN_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef enum int {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_BURSTY} ready_mode_type;
   typedef enum int {MIX_TIES, MIX_WIDE, MIX_EXTREMES, MIX_NEGATIVE} pixel_mix_type;

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [PEAK_BITS-1:0] req_pixel_value;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic                        rsp_found;
   logic signed [PEAK_BITS-1:0] rsp_peak_value;
   logic [POS_BITS-1:0]         rsp_peak_row;
   logic [POS_BITS-1:0]         rsp_peak_col;
   logic                        csr_we;
   logic [CSR_ADDR_BITS-1:0]    csr_index;
   logic [CFG_BITS-1:0]         csr_wdata;

   int             mismatches;
   int             awaiting;
   int             burst_left;
   bit             no_gaps;
   int unsigned    sent;
   int             frame_rows;
   int             frame_cols;
   int             stall_run = 0;
   ready_mode_type stall_mode = READY_ALWAYS;
   int             idle_count = 0;

   always #1 clock = ~clock;

   strict_local_maximum_peak_search uut (.*);

   peak_search_checker checker_i (.*);

   // receiver: ready pattern changes to a random mode at the end of each random-length run
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_mode <= ready_mode_type'($urandom_range(0, 3));
         stall_run  <= $urandom_range(8, 60);
      end else begin
         stall_run <= stall_run - 1;
      end
      case (stall_mode)
         READY_ALWAYS: rsp_ready <= 1'b1;
         READY_COIN:   rsp_ready <= 1'($urandom_range(0, 1));
         READY_SPARSE: rsp_ready <= ($urandom_range(0, 7) == 0);
         default:      rsp_ready <= stall_run[3];
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count == WATCHDOG_LIMIT) begin
         $display("tb_strict_local_maximum_peak_search: errors");
         $finish;
      end
   end

   task automatic push_pixel(input logic signed [PEAK_BITS-1:0] pix);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = no_gaps ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_pixel_value <= pix;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_BITS-1:0] idx,
                            input logic [CFG_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // out-of-range codes that land on the same size
   function automatic logic [CFG_BITS-1:0] dim_code(int dim);
      if (dim == 1 && $urandom_range(0, 2) == 0) return '0;
      if (dim == 64 && $urandom_range(0, 1) == 0) return CFG_BITS'($urandom_range(65, 127));
      return CFG_BITS'(dim);
   endfunction

   task automatic set_frame(input int rows, input int cols);
      drain_results();
      if ($urandom_range(0, 4) == 0)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, CFG_BITS'($urandom));
      csr_write(CSR_ROWS_IN_USE, dim_code(rows));
      csr_write(CSR_COLS_IN_USE, dim_code(cols));
      frame_rows = rows;
      frame_cols = cols;
   endtask

   function automatic logic signed [PEAK_BITS-1:0] pick_pixel(pixel_mix_type mix);
      case (mix)
         MIX_TIES: return $urandom_range(0, 8) - 3;
         MIX_WIDE: return $urandom;
         MIX_EXTREMES: begin
            case ($urandom_range(0, 5))
               0:       return 32'h7fff_ffff;
               1:       return 32'h8000_0000;
               2:       return -1;
               3:       return 0;
               4:       return 1;
               default: return $urandom;
            endcase
         end
         default: return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 3)
                                                     : 0 - $urandom_range(1, 100);
      endcase
   endfunction

   initial begin
      int            cross_pattern [9];
      int            rows;
      int            cols;
      int            len;
      int            cut;
      int            spare_at;
      pixel_mix_type mix;
      bit            reprogram;
      cross_pattern   = '{0, 1, 0, 1, 9, 1, 0, 1, 0};
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_pixel_value = '0;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      burst_left      = 0;
      no_gaps         = 1'b0;
      sent            = 0;
      frame_rows      = 1;
      frame_cols      = 1;
      reprogram       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // 1x1 frames with the reset sizes: lone cell, minus one, zero, extremes
      push_pixel(7);
      push_pixel(-1);
      push_pixel(0);
      push_pixel(32'h7fff_ffff);
      push_pixel(32'h8000_0000);

      // single row of three: tie goes to the first, equal neighbors are not strict
      drain_results();
      csr_write(CSR_SPARE_2, 7'h55);
      csr_write(CSR_ROWS_IN_USE, '0);
      csr_write(CSR_COLS_IN_USE, 7'd3);
      frame_rows = 1;
      frame_cols = 3;
      push_pixel(5);
      push_pixel(1);
      push_pixel(5);
      push_pixel(4);
      push_pixel(4);
      push_pixel(1);

      set_frame(3, 3);
      foreach (cross_pattern[k]) push_pixel(cross_pattern[k]);

      // tallest frame, row count clamped from above
      drain_results();
      csr_write(CSR_ROWS_IN_USE, 7'd127);
      csr_write(CSR_COLS_IN_USE, 7'd1);
      frame_rows = 64;
      frame_cols = 1;
      for (int k = 0; k < 64; k++) push_pixel(pick_pixel(MIX_TIES));

      while (sent < ITEM_TARGET) begin
         if (reprogram || $urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 19))
               0: begin
                  rows = 64;
                  cols = $urandom_range(1, 3);
               end
               1: begin
                  rows = $urandom_range(1, 3);
                  cols = 64;
               end
               default: begin
                  rows = $urandom_range(1, 8);
                  cols = $urandom_range(1, 8);
               end
            endcase
            set_frame(rows, cols);
         end
         reprogram = 1'b0;
         mix       = pixel_mix_type'($urandom_range(0, 3));
         no_gaps   = ($urandom_range(0, 3) == 0);
         len       = frame_rows * frame_cols;
         cut       = ($urandom_range(0, 11) == 0) ? $urandom_range(0, len - 1) : len;
         spare_at  = ($urandom_range(0, 15) == 0) ? $urandom_range(0, len - 1) : -1;
         for (int k = 0; k < cut; k++) begin
            if (k == spare_at) begin
               drain_results();
               csr_write($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3,
                         CFG_BITS'($urandom));
            end
            push_pixel(pick_pixel(mix));
         end
         // a partial frame is abandoned by the next size write
         if (cut < len) reprogram = 1'b1;
      end

      drain_results();
      if (mismatches == 0 && awaiting == 0)
         $display("tb_strict_local_maximum_peak_search: clean");
      else
         $display("tb_strict_local_maximum_peak_search: errors");
      $finish;
   end

endmodule

/* strict_local_maximum_peak_search.f */
+incdir+rtl/core
rtl/core/slmps_pkg.sv
rtl/core/strict_local_maximum_peak_search.sv
sim/peak_search_checker.sv
sim/tb_strict_local_maximum_peak_search.sv
